/* rtl/flptm_pkg.sv */
`default_nettype none
package flptm_pkg;
	localparam int TABLE_PAGES = 64;
	localparam int PG_W = $clog2(TABLE_PAGES);
	localparam int SLOT_W = PG_W + 9;
	localparam int NFP_W = PG_W + 1;

	localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] PTE_P = 64'h1;
	localparam logic [63:0] PTE_W = 64'h2;
	localparam logic [63:0] PTE_U = 64'h4;
	localparam logic [63:0] PTE_NX = 64'h8000_0000_0000_0000;
	localparam logic [14:0] COUNT_MAX = 15'h7fff;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_MAP_USER = 3'd1;
	localparam logic [2:0] OP_MAP_KERN = 3'd2;
	localparam logic [2:0] OP_MAP_SUP = 3'd3;
	localparam logic [2:0] OP_UNMAP = 3'd4;
	localparam logic [2:0] OP_XLATE = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OOM = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_EXISTS = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;

	localparam logic [1:0] CFG_USER_BASE = 2'd0;
	localparam logic [1:0] CFG_USER_TOP = 2'd1;
	localparam logic [1:0] CFG_POOL_BASE = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] virt_addr;
		logic [51:0] phys_addr;
		logic        writable;
		logic        no_execute;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [51:0] phys_out;
		logic [63:0] leaf_entry;
		logic [14:0] mapped_pages;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_RD, S_WAIT, S_EVAL, S_ZERO, S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [63:0]       wdata;
	} mem_req_t;
endpackage
`default_nettype wire

/* rtl/four_level_page_table_manager.sv */
`default_nettype none
// Four-level page table manager.
// Request channel: req is taken at a rising edge with start high and busy
// low. busy stays high until the result has been shown.
// Result channel: rsp is valid for one cycle while done is high; the
// receiver cannot stall it, so it must take the result in that cycle.
// Configuration: cfg_we with cfg_idx and cfg_wdata writes one register;
// write only while busy is low.
// Table walk: one table store read per level through a single port with
// registered read data, in three steps per level (address, wait, evaluate).
// Each table page allocated during a map is zeroed, all 512 entries, one
// entry a cycle; create zeroes the root page the same way. Checks run
// first, in their own state.
// The table store has no reset; reset clears next_free_page, the root flag,
// mapped count and pool base and loads the user range defaults, so create
// must be issued before mapping. Invalid opcodes return invalid address.
module four_level_page_table_manager (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire flptm_pkg::req_t    req,
	output logic                    done,
	output flptm_pkg::rsp_t         rsp,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [51:0]        cfg_wdata
);
	localparam int PW = flptm_pkg::PG_W;

	flptm_pkg::state_t state_q, state_d;
	flptm_pkg::req_t req_q;
	logic [47:0] ubase_q, utop_q;
	logic [51:0] pool_q;
	logic [flptm_pkg::NFP_W-1:0] nfp_q;
	logic root_q;
	logic [14:0] cnt_q;
	logic [1:0] lvl_q;
	logic [PW-1:0] pg_q;
	logic [8:0] zidx_q;
	logic [2:0] st_q;
	logic [63:0] leaf_q;
	logic [63:0] rdata;
	flptm_pkg::mem_req_t mreq;

	flptm_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

	logic [8:0] ix;
	logic is_map, user;
	logic canon, in_user, chk_bad;
	logic [51:0] off;
	logic in_pool;
	logic [PW-1:0] child;
	logic oom;
	logic [63:0] tbl_entry, new_leaf;
	logic [51:0] nfp_addr;

	// level index and decode
	always_comb begin
		case (lvl_q)
			2'd0: ix = req_q.virt_addr[47:39];
			2'd1: ix = req_q.virt_addr[38:30];
			2'd2: ix = req_q.virt_addr[29:21];
			default: ix = req_q.virt_addr[20:12];
		endcase
		is_map = (req_q.opcode == flptm_pkg::OP_MAP_USER) ||
			(req_q.opcode == flptm_pkg::OP_MAP_KERN) ||
			(req_q.opcode == flptm_pkg::OP_MAP_SUP);
		user = req_q.opcode == flptm_pkg::OP_MAP_USER;
		canon = (&req_q.virt_addr[63:47]) || !(|req_q.virt_addr[63:47]);
		in_user = (req_q.virt_addr[47:0] >= ubase_q) && (req_q.virt_addr[47:0] < utop_q)
			&& !(|req_q.virt_addr[63:48]);
		chk_bad = !root_q || !canon;
		case (req_q.opcode)
			flptm_pkg::OP_MAP_USER: chk_bad = chk_bad || (|req_q.virt_addr[11:0])
				|| (|req_q.phys_addr[11:0]) || !in_user;
			flptm_pkg::OP_MAP_KERN: chk_bad = chk_bad || (|req_q.virt_addr[11:0])
				|| (|req_q.phys_addr[11:0]) || in_user;
			flptm_pkg::OP_MAP_SUP: chk_bad = chk_bad || (|req_q.virt_addr[11:0])
				|| (|req_q.phys_addr[11:0]);
			flptm_pkg::OP_UNMAP: chk_bad = chk_bad || (|req_q.virt_addr[11:0]);
			flptm_pkg::OP_XLATE: chk_bad = chk_bad;
			default: chk_bad = 1'b1;
		endcase
		off = {rdata[51:12], 12'h000} - {pool_q[51:12], 12'h000};
		in_pool = !(|off[51:12+PW]);
		child = off[12+PW-1:12];
		oom = nfp_q >= flptm_pkg::NFP_W'(flptm_pkg::TABLE_PAGES);
		nfp_addr = {pool_q[51:12], 12'h000} + {{(40-PW){1'b0}}, nfp_q[PW-1:0], 12'h000};
		tbl_entry = ({12'h000, nfp_addr} & flptm_pkg::ADDR_MASK) | flptm_pkg::PTE_P
			| flptm_pkg::PTE_W | (user ? flptm_pkg::PTE_U : 64'h0);
		new_leaf = ({12'h000, req_q.phys_addr} & flptm_pkg::ADDR_MASK) | flptm_pkg::PTE_P
			| (user ? flptm_pkg::PTE_U : 64'h0) | (req_q.writable ? flptm_pkg::PTE_W : 64'h0)
			| (req_q.no_execute ? flptm_pkg::PTE_NX : 64'h0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			flptm_pkg::S_IDLE: if (start) state_d = flptm_pkg::S_CHECK;
			flptm_pkg::S_CHECK: begin
				if (req_q.opcode == flptm_pkg::OP_CREATE) state_d = flptm_pkg::S_ZERO;
				else if (chk_bad) state_d = flptm_pkg::S_DONE;
				else state_d = flptm_pkg::S_RD;
			end
			flptm_pkg::S_RD: state_d = flptm_pkg::S_WAIT;
			flptm_pkg::S_WAIT: state_d = flptm_pkg::S_EVAL;
			flptm_pkg::S_EVAL: begin
				if (lvl_q == 2'd3) state_d = flptm_pkg::S_DONE;
				else if (!rdata[0]) begin
					if (is_map && !oom) state_d = flptm_pkg::S_ZERO;
					else state_d = flptm_pkg::S_DONE;
				end else if ((is_map && user && !rdata[2]) || !in_pool)
					state_d = flptm_pkg::S_DONE;
				else state_d = flptm_pkg::S_RD;
			end
			flptm_pkg::S_ZERO: begin
				if (&zidx_q) state_d = (req_q.opcode == flptm_pkg::OP_CREATE) ?
					flptm_pkg::S_DONE : flptm_pkg::S_RD;
			end
			flptm_pkg::S_DONE: state_d = flptm_pkg::S_IDLE;
			default: state_d = flptm_pkg::S_IDLE;
		endcase
	end

	// outputs and store port
	always_comb begin
		busy = state_q != flptm_pkg::S_IDLE;
		done = state_q == flptm_pkg::S_DONE;
		rsp.status = st_q;
		rsp.phys_out = (st_q == flptm_pkg::ST_OK && req_q.opcode == flptm_pkg::OP_XLATE) ?
			{leaf_q[51:12], req_q.virt_addr[11:0]} : 52'h0;
		rsp.leaf_entry = (st_q == flptm_pkg::ST_OK && req_q.opcode == flptm_pkg::OP_XLATE) ?
			leaf_q : 64'h0;
		rsp.mapped_pages = cnt_q;
		mreq.we = 1'b0;
		mreq.addr = {pg_q, ix};
		mreq.wdata = 64'h0;
		case (state_q)
			flptm_pkg::S_ZERO: begin
				mreq.we = 1'b1;
				mreq.addr = {pg_q, zidx_q};
			end
			flptm_pkg::S_EVAL: begin
				if (lvl_q == 2'd3) begin
					if (is_map && !rdata[0]) begin
						mreq.we = 1'b1;
						mreq.wdata = new_leaf;
					end else if (req_q.opcode == flptm_pkg::OP_UNMAP && rdata[0]) begin
						mreq.we = 1'b1;
					end
				end else if (!rdata[0] && is_map && !oom) begin
					mreq.we = 1'b1;
					mreq.wdata = tbl_entry;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flptm_pkg::S_IDLE;
			ubase_q <= 48'h40_0000;
			utop_q <= 48'h8000_0000_0000;
			pool_q <= 52'h0;
			nfp_q <= '0;
			root_q <= 1'b0;
			cnt_q <= 15'h0;
			lvl_q <= 2'd0;
			zidx_q <= 9'h0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					flptm_pkg::CFG_USER_BASE: ubase_q <= cfg_wdata[47:0];
					flptm_pkg::CFG_USER_TOP: utop_q <= cfg_wdata[47:0];
					flptm_pkg::CFG_POOL_BASE: pool_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				flptm_pkg::S_CHECK: begin
					lvl_q <= 2'd0;
					zidx_q <= 9'h0;
					if (req_q.opcode == flptm_pkg::OP_CREATE) begin
						nfp_q <= flptm_pkg::NFP_W'(1);
						root_q <= 1'b1;
						cnt_q <= 15'h0;
					end
				end
				flptm_pkg::S_ZERO: zidx_q <= zidx_q + 9'd1;
				flptm_pkg::S_EVAL: begin
					if (lvl_q == 2'd3) begin
						if (is_map && !rdata[0] && cnt_q != flptm_pkg::COUNT_MAX)
							cnt_q <= cnt_q + 15'd1;
						else if (req_q.opcode == flptm_pkg::OP_UNMAP && rdata[0]
							&& cnt_q != 15'h0)
							cnt_q <= cnt_q - 15'd1;
					end else begin
						lvl_q <= lvl_q + 2'd1;
						if (!rdata[0] && is_map && !oom)
							nfp_q <= nfp_q + flptm_pkg::NFP_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			flptm_pkg::S_IDLE: if (start) req_q <= req;
			flptm_pkg::S_CHECK: begin
				pg_q <= '0;
				st_q <= (req_q.opcode != flptm_pkg::OP_CREATE && chk_bad) ?
					flptm_pkg::ST_INVALID : flptm_pkg::ST_OK;
			end
			flptm_pkg::S_EVAL: begin
				leaf_q <= rdata;
				if (lvl_q == 2'd3) begin
					if (is_map) st_q <= rdata[0] ? flptm_pkg::ST_EXISTS : flptm_pkg::ST_OK;
					else st_q <= rdata[0] ? flptm_pkg::ST_OK : flptm_pkg::ST_MISSING;
				end else if (!rdata[0]) begin
					if (!is_map) st_q <= flptm_pkg::ST_MISSING;
					else if (oom) st_q <= flptm_pkg::ST_OOM;
					else pg_q <= nfp_q[PW-1:0];
				end else if (is_map && user && !rdata[2]) st_q <= flptm_pkg::ST_INVALID;
				else if (!in_pool) st_q <= is_map ? flptm_pkg::ST_INVALID : flptm_pkg::ST_MISSING;
				else pg_q <= child;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy) |=> (cnt_q == $past(cnt_q))) else $error("count moved while idle");
`endif
endmodule
`default_nettype wire

/* rtl/flptm_store.sv */
`default_nettype none
module flptm_store (
	input  wire logic                clk,
	input  wire flptm_pkg::mem_req_t req,
	output logic [63:0]              rdata
);
	logic [63:0] mem [flptm_pkg::TABLE_PAGES*512];

	// write or read one entry, read data registered
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule
`default_nettype wire
